// ===== hdl/ckb_pkg.sv =====
// ----------------------------------------------------------------------------
// ckb_pkg: shared types and constants of the knot splitter
// Knot and coefficient formats, status codes and the pipeline stage record.
// ----------------------------------------------------------------------------
package ckb_pkg;

   localparam int KNOT_BITS  = 32;
   localparam int FRAC_BITS  = 16;
   localparam int TOL_BITS   = 16;
   localparam int DIFF_BITS  = KNOT_BITS + 2;
   localparam int COEF_BITS  = FRAC_BITS + 1;
   localparam int NUM_KNOTS  = 5;
   localparam int NUM_MERGED = 6;
   localparam int IV_BITS    = 2;
   localparam int STAT_BITS  = 2;

   localparam logic [TOL_BITS-1:0]  TOL_RESET = TOL_BITS'(1);
   localparam logic [COEF_BITS-1:0] COEF_ONE  = COEF_BITS'(1) << FRAC_BITS;

   localparam logic [STAT_BITS-1:0] STATUS_OK       = 2'd0;
   localparam logic [STAT_BITS-1:0] STATUS_BOUNDS   = 2'd1;
   localparam logic [STAT_BITS-1:0] STATUS_ON_KNOT  = 2'd2;
   localparam logic [STAT_BITS-1:0] STATUS_UNSORTED = 2'd3;

   typedef logic signed [KNOT_BITS-1:0] knot_type;
   typedef logic signed [DIFF_BITS-1:0] diff_type;

   // One item on its way through the divider stages.
   typedef struct packed {
      logic                             valid;
      logic [STAT_BITS-1:0]             status;
      logic [IV_BITS-1:0]               iv;
      logic [NUM_MERGED-1:0][KNOT_BITS-1:0] merged;
      logic                             force_l;
      logic                             force_r;
      logic [DIFF_BITS-1:0]             rem_l;
      logic [DIFF_BITS-1:0]             den_l;
      logic [DIFF_BITS-1:0]             rem_r;
      logic [DIFF_BITS-1:0]             den_r;
      logic [FRAC_BITS-1:0]             q_l;
      logic [FRAC_BITS-1:0]             q_r;
   } div_type;

endpackage

// ===== hdl/ckb_if.sv =====
// ----------------------------------------------------------------------------
// ckb_if: channel interfaces of the knot splitter
// Request, response and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface ckb_req_if;
   logic               valid;
   logic               ready;
   ckb_pkg::knot_type  knot_a;
   ckb_pkg::knot_type  knot_b;
   ckb_pkg::knot_type  knot_c;
   ckb_pkg::knot_type  knot_d;
   ckb_pkg::knot_type  knot_e;
   ckb_pkg::knot_type  new_knot;
   modport source (output valid, knot_a, knot_b, knot_c, knot_d, knot_e, new_knot,
                   input ready);
   modport sink   (input valid, knot_a, knot_b, knot_c, knot_d, knot_e, new_knot,
                   output ready);
endinterface

interface ckb_rsp_if;
   logic                                valid;
   logic                                ready;
   ckb_pkg::knot_type                   merged_0;
   ckb_pkg::knot_type                   merged_1;
   ckb_pkg::knot_type                   merged_2;
   ckb_pkg::knot_type                   merged_3;
   ckb_pkg::knot_type                   merged_4;
   ckb_pkg::knot_type                   merged_5;
   logic [ckb_pkg::IV_BITS-1:0]         interval;
   logic [ckb_pkg::COEF_BITS-1:0]       coef_left;
   logic [ckb_pkg::COEF_BITS-1:0]       coef_right;
   logic [ckb_pkg::STAT_BITS-1:0]       status;
   modport source (output valid, merged_0, merged_1, merged_2, merged_3, merged_4,
                   merged_5, interval, coef_left, coef_right, status, input ready);
   modport sink   (input valid, merged_0, merged_1, merged_2, merged_3, merged_4,
                   merged_5, interval, coef_left, coef_right, status, output ready);
endinterface

interface ckb_csr_if;
   logic                              valid;
   logic                              ready;
   logic [ckb_pkg::TOL_BITS-1:0]      tolerance;
   modport source (output valid, tolerance, input ready);
   modport sink   (input valid, tolerance, output ready);
endinterface

// ===== hdl/cubic_basis_knot_split.sv =====
// ----------------------------------------------------------------------------
// cubic_basis_knot_split: knot insertion into one cubic basis function
// Pipeline from request to response: two front stages, sixteen division
// steps, one output register. Throughput: one request per cycle unless the
// output is stalled. The sixteen single-bit division stages set the latency.
// Synchronous reset empties the pipeline and sets tolerance to 1.
// ----------------------------------------------------------------------------
module cubic_basis_knot_split (
   input  logic        clock,
   input  logic        reset,
   ckb_req_if.sink     req_chan,
   ckb_rsp_if.source   rsp_chan,
   ckb_csr_if.sink     csr_chan
);

   // The tolerance register. Writes are always accepted; the user only writes
   // it while no request is in flight.
   logic [ckb_pkg::TOL_BITS-1:0] tol_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= ckb_pkg::TOL_RESET;
      end else if (csr_chan.valid) begin
         tol_ff <= csr_chan.tolerance;
      end
   end

   // The whole pipeline moves as one whenever the output register is empty or
   // being emptied, so nothing is lost or repeated during a stall.
   logic enable;
   logic out_valid_ff;

   assign enable         = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = enable;

   ckb_pkg::knot_type [4:0] knots;

   assign knots[0] = req_chan.knot_a;
   assign knots[1] = req_chan.knot_b;
   assign knots[2] = req_chan.knot_c;
   assign knots[3] = req_chan.knot_d;
   assign knots[4] = req_chan.knot_e;

   ckb_pkg::div_type stg [0:ckb_pkg::FRAC_BITS];

   // Differences, status, interval and merged knots.
   ckb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (req_chan.valid),
      .knots_in (knots),
      .new_in   (req_chan.new_knot),
      .tol      (tol_ff),
      .out      (stg[0])
   );

   // One quotient bit of each coefficient per stage.
   for (genvar i = 0; i < ckb_pkg::FRAC_BITS; i++) begin : g_div
      ckb_div_step u_step (
         .clock  (clock),
         .reset  (reset),
         .enable (enable),
         .d_in   (stg[i]),
         .d_out  (stg[i+1])
      );
   end

   // Output register: coefficients are forced to one where the interval or a
   // double knot calls for it; merged knots, interval and coefficients are cleared on an error.
   ckb_pkg::div_type                     fin;
   logic                                 ok;
   logic [ckb_pkg::NUM_MERGED-1:0][ckb_pkg::KNOT_BITS-1:0] merged_in;
   logic [ckb_pkg::NUM_MERGED-1:0][ckb_pkg::KNOT_BITS-1:0] merged_ff;
   logic [ckb_pkg::IV_BITS-1:0]          iv_in;
   logic [ckb_pkg::IV_BITS-1:0]          iv_ff;
   logic [ckb_pkg::COEF_BITS-1:0]        cl_in;
   logic [ckb_pkg::COEF_BITS-1:0]        cl_ff;
   logic [ckb_pkg::COEF_BITS-1:0]        cr_in;
   logic [ckb_pkg::COEF_BITS-1:0]        cr_ff;
   logic [ckb_pkg::STAT_BITS-1:0]        status_ff;

   always_comb begin
      fin       = stg[ckb_pkg::FRAC_BITS];
      ok        = fin.status == ckb_pkg::STATUS_OK;
      merged_in = ok ? fin.merged : '0;
      iv_in     = ok ? fin.iv : '0;
      if (!ok) begin
         cl_in = '0;
      end else if (fin.force_l) begin
         cl_in = ckb_pkg::COEF_ONE;
      end else begin
         cl_in = {1'b0, fin.q_l};
      end
      if (!ok) begin
         cr_in = '0;
      end else if (fin.force_r) begin
         cr_in = ckb_pkg::COEF_ONE;
      end else begin
         cr_in = {1'b0, fin.q_r};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= fin.valid;
         merged_ff    <= merged_in;
         iv_ff        <= iv_in;
         cl_ff        <= cl_in;
         cr_ff        <= cr_in;
         status_ff    <= fin.status;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.merged_0   = merged_ff[0];
   assign rsp_chan.merged_1   = merged_ff[1];
   assign rsp_chan.merged_2   = merged_ff[2];
   assign rsp_chan.merged_3   = merged_ff[3];
   assign rsp_chan.merged_4   = merged_ff[4];
   assign rsp_chan.merged_5   = merged_ff[5];
   assign rsp_chan.interval   = iv_ff;
   assign rsp_chan.coef_left  = cl_ff;
   assign rsp_chan.coef_right = cr_ff;
   assign rsp_chan.status     = status_ff;

endmodule

// ===== hdl/ckb_front.sv =====
// ----------------------------------------------------------------------------
// ckb_front: knot differences and classification
// Two register stages: differences to the new knot, then status, interval,
// merged knots and the divider operands.
// ----------------------------------------------------------------------------
module ckb_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               enable,
   input  logic                               in_valid,
   input  ckb_pkg::knot_type [4:0]            knots_in,
   input  ckb_pkg::knot_type                  new_in,
   input  logic [ckb_pkg::TOL_BITS-1:0]       tol,
   output ckb_pkg::div_type                   out
);

   logic                     s1_valid_ff;
   ckb_pkg::knot_type [4:0]  s1_n_ff;
   ckb_pkg::knot_type        s1_k_ff;
   ckb_pkg::diff_type [4:0]  s1_dk_ff;
   ckb_pkg::diff_type        s1_den_l_ff;
   ckb_pkg::diff_type        s1_den_r_ff;
   ckb_pkg::diff_type [4:0]  dk_in;
   ckb_pkg::div_type         out_ff;
   ckb_pkg::div_type         out_in;

   always_comb begin
      for (int i = 0; i < ckb_pkg::NUM_KNOTS; i++) begin
         dk_in[i] = ckb_pkg::DIFF_BITS'(new_in) - ckb_pkg::DIFF_BITS'(knots_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_valid_ff <= in_valid;
         s1_n_ff     <= knots_in;
         s1_k_ff     <= new_in;
         s1_dk_ff    <= dk_in;
         s1_den_l_ff <= ckb_pkg::DIFF_BITS'(knots_in[3]) - ckb_pkg::DIFF_BITS'(knots_in[0]);
         s1_den_r_ff <= ckb_pkg::DIFF_BITS'(knots_in[4]) - ckb_pkg::DIFF_BITS'(knots_in[1]);
      end
   end

   ckb_pkg::diff_type tol_s;
   ckb_pkg::diff_type tol_n;
   logic [4:0]        k_above;
   logic [4:0]        n_above;
   logic              near_any;
   logic              sorted;
   logic              found;
   logic [1:0]        iv;
   logic [1:0]        status;
   ckb_pkg::diff_type num_r;

   always_comb begin
      tol_s = {{(ckb_pkg::DIFF_BITS - ckb_pkg::TOL_BITS){1'b0}}, tol};
      tol_n = -tol_s;
      for (int i = 0; i < ckb_pkg::NUM_KNOTS; i++) begin
         k_above[i] = s1_dk_ff[i] > tol_s;
         n_above[i] = s1_dk_ff[i] < tol_n;
      end
      near_any = 1'b0;
      for (int i = 1; i < 4; i++) begin
         near_any = near_any | (!k_above[i] && !n_above[i]);
      end
      sorted = (s1_n_ff[0] <= s1_n_ff[1]) && (s1_n_ff[1] <= s1_n_ff[2]) &&
               (s1_n_ff[2] <= s1_n_ff[3]) && (s1_n_ff[3] <= s1_n_ff[4]);
      found = 1'b0;
      iv    = 2'd0;
      for (int i = 0; i < 4; i++) begin
         if (!found && k_above[i] && n_above[i+1]) begin
            found = 1'b1;
            iv    = 2'(i);
         end
      end
      if (!k_above[0] || !n_above[4]) begin
         status = ckb_pkg::STATUS_BOUNDS;
      end else if (near_any) begin
         status = ckb_pkg::STATUS_ON_KNOT;
      end else if (!sorted || !found) begin
         status = ckb_pkg::STATUS_UNSORTED;
      end else begin
         status = ckb_pkg::STATUS_OK;
      end
      num_r = -s1_dk_ff[4];

      out_in.valid  = s1_valid_ff;
      out_in.status = status;
      out_in.iv     = iv;
      // The first and last merged knots are always the end knots.
      out_in.merged[0] = s1_n_ff[0];
      for (int j = 1; j < ckb_pkg::NUM_MERGED - 1; j++) begin
         if (j <= int'(iv)) begin
            out_in.merged[j] = s1_n_ff[j];
         end else if (j == int'(iv) + 1) begin
            out_in.merged[j] = s1_k_ff;
         end else begin
            out_in.merged[j] = s1_n_ff[j-1];
         end
      end
      out_in.merged[ckb_pkg::NUM_MERGED-1] = s1_n_ff[4];
      out_in.force_l = (iv == 2'd3) || (iv == 2'd2 && s1_n_ff[1] == s1_n_ff[2]);
      out_in.force_r = (iv == 2'd0) || (iv == 2'd1 && s1_n_ff[2] == s1_n_ff[3]);
      out_in.rem_l   = s1_dk_ff[0];
      out_in.den_l   = s1_den_l_ff;
      out_in.rem_r   = num_r;
      out_in.den_r   = s1_den_r_ff;
      out_in.q_l     = '0;
      out_in.q_r     = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (enable) begin
         out_ff <= out_in;
      end
   end

   assign out = out_ff;

endmodule

// ===== hdl/ckb_div_step.sv =====
// ----------------------------------------------------------------------------
// ckb_div_step: one restoring division step for both coefficients
// Produces one quotient bit of each fraction and registers the item.
// ----------------------------------------------------------------------------
module ckb_div_step (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  ckb_pkg::div_type  d_in,
   output ckb_pkg::div_type  d_out
);

   logic [ckb_pkg::DIFF_BITS:0] dbl_l;
   logic [ckb_pkg::DIFF_BITS:0] dbl_r;
   logic                        take_l;
   logic                        take_r;
   ckb_pkg::div_type            d_out_in;
   ckb_pkg::div_type            d_out_ff;

   always_comb begin
      dbl_l  = {d_in.rem_l, 1'b0};
      dbl_r  = {d_in.rem_r, 1'b0};
      take_l = dbl_l >= {1'b0, d_in.den_l};
      take_r = dbl_r >= {1'b0, d_in.den_r};
      d_out_in = d_in;
      d_out_in.rem_l = take_l ? ckb_pkg::DIFF_BITS'(dbl_l - {1'b0, d_in.den_l})
                              : ckb_pkg::DIFF_BITS'(dbl_l);
      d_out_in.rem_r = take_r ? ckb_pkg::DIFF_BITS'(dbl_r - {1'b0, d_in.den_r})
                              : ckb_pkg::DIFF_BITS'(dbl_r);
      d_out_in.q_l = {d_in.q_l[ckb_pkg::FRAC_BITS-2:0], take_l};
      d_out_in.q_r = {d_in.q_r[ckb_pkg::FRAC_BITS-2:0], take_r};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_out_ff.valid <= 1'b0;
      end else if (enable) begin
         d_out_ff <= d_out_in;
      end
   end

   assign d_out = d_out_ff;

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench of the cubic basis knot splitter
// Requests go in through the request channel with random bursts and gaps.
// Responses are drained with a changing stall pattern. A scoreboard predicts
// every response from the knots and the current tolerance and checks each
// field. The tolerance is rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY   = 19;
   localparam int MAX_CYCLE = 600000;

   typedef struct {
      ckb_pkg::knot_type                      merged [ckb_pkg::NUM_MERGED];
      logic [ckb_pkg::IV_BITS-1:0]            interval;
      logic [ckb_pkg::COEF_BITS-1:0]          coef_left;
      logic [ckb_pkg::COEF_BITS-1:0]          coef_right;
      logic [ckb_pkg::STAT_BITS-1:0]          status;
   } split_result_type;

   // Predicts the split of one basis function and keeps the responses that
   // are still owed, oldest first.
   class scoreboard_type;
      split_result_type owed [$];
      longint           tol = ckb_pkg::TOL_RESET;
      int               mismatches = 0;

      function bit above(longint a, longint b);
         return a > b + tol;
      endfunction

      function bit near(longint a, longint b);
         return ((a >= b) ? a - b : b - a) <= tol;
      endfunction

      // Restoring division, truncated to FRAC_BITS fraction bits.
      function logic [ckb_pkg::COEF_BITS-1:0] quotient(longint num, longint den);
         longint q;
         longint r;
         q = 0;
         r = num;
         if (den == 0) return '0;
         if (num >= den) return ckb_pkg::COEF_ONE;
         for (int i = 0; i < ckb_pkg::FRAC_BITS; i++) begin
            q = q << 1;
            if (r >= den - r) begin
               r = r - (den - r);
               q = q | 1;
            end else begin
               r = r + r;
            end
         end
         return ckb_pkg::COEF_BITS'(q);
      endfunction

      function void note_request(ckb_pkg::knot_type a, ckb_pkg::knot_type b,
                                 ckb_pkg::knot_type c, ckb_pkg::knot_type d,
                                 ckb_pkg::knot_type e, ckb_pkg::knot_type nk);
         longint           n [5];
         longint           k;
         split_result_type res;
         int               iv;
         int               j;
         logic [ckb_pkg::COEF_BITS-1:0] lq, rq;
         n[0] = a; n[1] = b; n[2] = c; n[3] = d; n[4] = e;
         k = nk;
         iv = 0;
         foreach (res.merged[i]) res.merged[i] = '0;
         res.interval = '0;
         res.coef_left = '0;
         res.coef_right = '0;
         if (!above(k, n[0]) || !above(n[4], k))
            res.status = ckb_pkg::STATUS_BOUNDS;
         else if (near(k, n[1]) || near(k, n[2]) || near(k, n[3]))
            res.status = ckb_pkg::STATUS_ON_KNOT;
         else if (!(n[0] <= n[1] && n[1] <= n[2] && n[2] <= n[3] && n[3] <= n[4]))
            res.status = ckb_pkg::STATUS_UNSORTED;
         else begin
            res.status = ckb_pkg::STATUS_UNSORTED;
            for (int i = 0; i < 4; i++) begin
               if (res.status != ckb_pkg::STATUS_OK && above(k, n[i]) &&
                   above(n[i+1], k)) begin
                  iv = i;
                  res.status = ckb_pkg::STATUS_OK;
               end
            end
         end
         if (res.status == ckb_pkg::STATUS_OK) begin
            lq = quotient(k - n[0], n[3] - n[0]);
            rq = quotient(n[4] - k, n[4] - n[1]);
            case (iv)
               0: begin res.coef_left = lq; res.coef_right = ckb_pkg::COEF_ONE; end
               1: begin
                  res.coef_left = lq;
                  res.coef_right = (n[2] == n[3]) ? ckb_pkg::COEF_ONE : rq;
               end
               2: begin
                  res.coef_left = (n[1] == n[2]) ? ckb_pkg::COEF_ONE : lq;
                  res.coef_right = rq;
               end
               default: begin res.coef_left = ckb_pkg::COEF_ONE; res.coef_right = rq; end
            endcase
            j = 0;
            for (int i = 0; i < 5; i++) begin
               res.merged[j++] = ckb_pkg::knot_type'(n[i]);
               if (i == iv) res.merged[j++] = ckb_pkg::knot_type'(k);
            end
            res.interval = ckb_pkg::IV_BITS'(iv);
         end
         owed = {owed, res};
      endfunction

      task report(string what, longint got, longint want);
         $display("ERROR at %0t: %s got %0d, wanted %0d", $realtime, what, got, want);
         mismatches++;
      endtask

      task check_response(split_result_type got);
         split_result_type want;
         if (owed.size() == 0) begin
            report("response with none owed, status", got.status, 0);
            return;
         end
         want = owed.pop_front();
         foreach (want.merged[i])
            if (got.merged[i] !== want.merged[i])
               report($sformatf("merged_%0d", i), got.merged[i], want.merged[i]);
         if (got.interval !== want.interval) report("interval", got.interval, want.interval);
         if (got.coef_left !== want.coef_left)
            report("coef_left", got.coef_left, want.coef_left);
         if (got.coef_right !== want.coef_right)
            report("coef_right", got.coef_right, want.coef_right);
         if (got.status !== want.status) report("status", got.status, want.status);
      endtask
   endclass

   logic clock;
   logic reset;
   int   cycle;
   int   stall_mode;

   ckb_req_if req_chan ();
   ckb_rsp_if rsp_chan ();
   ckb_csr_if csr_chan ();

   scoreboard_type board = new();

   cubic_basis_knot_split u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // Accepted requests and register writes are noted here, responses are
   // checked here. All values are read at the edge, before any update lands.
   always @(posedge clock) begin
      split_result_type got;
      cycle <= cycle + 1;
      if (!reset) begin
         if (csr_chan.valid && csr_chan.ready) board.tol = csr_chan.tolerance;
         if (req_chan.valid && req_chan.ready)
            board.note_request(req_chan.knot_a, req_chan.knot_b, req_chan.knot_c,
                               req_chan.knot_d, req_chan.knot_e, req_chan.new_knot);
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.merged[0] = rsp_chan.merged_0;
            got.merged[1] = rsp_chan.merged_1;
            got.merged[2] = rsp_chan.merged_2;
            got.merged[3] = rsp_chan.merged_3;
            got.merged[4] = rsp_chan.merged_4;
            got.merged[5] = rsp_chan.merged_5;
            got.interval = rsp_chan.interval;
            got.coef_left = rsp_chan.coef_left;
            got.coef_right = rsp_chan.coef_right;
            got.status = rsp_chan.status;
            board.check_response(got);
         end
      end
   end

   // The receiver changes its habit periodically: always ready, half the
   // time, or mostly stalled. The first stretch runs without stalls.
   always @(posedge clock) begin
      if (cycle % 64 == 0) stall_mode <= (cycle == 0) ? 0 : $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_chan.ready <= 1'b1;
         1: rsp_chan.ready <= 1'($urandom_range(0, 1));
         default: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // A runaway run is cut off here.
   always @(posedge clock) begin
      if (cycle >= MAX_CYCLE) begin
         $display("Mismatches found");
         $finish;
      end
   end

   int burst_left;

   // Drives one request and holds it until it is taken. Between bursts the
   // valid is lowered for a random gap.
   task send_request(ckb_pkg::knot_type a, ckb_pkg::knot_type b, ckb_pkg::knot_type c,
                     ckb_pkg::knot_type d, ckb_pkg::knot_type e, ckb_pkg::knot_type k);
      req_chan.valid <= 1'b1;
      req_chan.knot_a <= a;
      req_chan.knot_b <= b;
      req_chan.knot_c <= c;
      req_chan.knot_d <= d;
      req_chan.knot_e <= e;
      req_chan.new_knot <= k;
      do @(posedge clock); while (!req_chan.ready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 20);
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Lets the pipeline empty before the tolerance is touched. The request
   // valid is lowered first so that the last request is not taken again.
   task drain;
      req_chan.valid <= 1'b0;
      while (board.owed.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task write_tolerance(logic [ckb_pkg::TOL_BITS-1:0] value);
      drain();
      csr_chan.valid <= 1'b1;
      csr_chan.tolerance <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly a sorted knot set with a new knot that is mostly inside the support,
   // sometimes next to any knot and sometimes anywhere at all; else all random.
   task random_request;
      longint            n [5];
      longint            k;
      longint            span;
      int                pick;
      ckb_pkg::knot_type raw [$];
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         send_request($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         return;
      end
      if (pick < 50) begin
         for (int i = 0; i < 5; i++) raw = {raw, ckb_pkg::knot_type'($urandom)};
         raw.sort();
         for (int i = 0; i < 5; i++) n[i] = raw[i];
      end else begin
         n[0] = ckb_pkg::knot_type'($urandom) >>> $urandom_range(1, 12);
         for (int i = 1; i < 5; i++)
            n[i] = n[i-1] + (($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 300000));
         if (n[4] > 64'sd2147483647) for (int i = 0; i < 5; i++) n[i] -= 64'sd1 << 31;
      end
      // Occasionally a pair of knots collapses into a double knot.
      if ($urandom_range(0, 5) == 0) begin
         pick = $urandom_range(1, 3);
         n[pick] = n[pick + $urandom_range(0, 1) * 2 - 1];
      end
      pick = $urandom_range(0, 99);
      span = n[4] - n[0] + 1;
      if (pick < 75) k = n[0] + longint'({$urandom, $urandom} % span);
      else if (pick < 92) k = n[$urandom_range(0, 4)]
                              + longint'($urandom_range(0, board.tol + 2))
                              * ($urandom_range(0, 1) ? 1 : -1);
      else k = ckb_pkg::knot_type'($urandom);
      if (k > 64'sd2147483647) k = 64'sd2147483647;
      if (k < -64'sd2147483648) k = -64'sd2147483648;
      send_request(ckb_pkg::knot_type'(n[0]), ckb_pkg::knot_type'(n[1]),
                   ckb_pkg::knot_type'(n[2]), ckb_pkg::knot_type'(n[3]),
                   ckb_pkg::knot_type'(n[4]), ckb_pkg::knot_type'(k));
   endtask

   localparam ckb_pkg::knot_type KMAX = 32'sh7FFF_FFFF;
   localparam ckb_pkg::knot_type KMIN = 32'sh8000_0000;
   localparam ckb_pkg::knot_type ONE  = 32'sh0001_0000;

   logic [ckb_pkg::TOL_BITS-1:0] tol_plan [5];

   initial begin
      reset = 1'b1;
      cycle = 0;
      stall_mode = 0;
      burst_left = 0;
      req_chan.valid = 1'b0;
      req_chan.knot_a = '0;
      req_chan.knot_b = '0;
      req_chan.knot_c = '0;
      req_chan.knot_d = '0;
      req_chan.knot_e = '0;
      req_chan.new_knot = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.tolerance = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests at the reset tolerance of one LSB.
      // The new knot falls in each of the four intervals in turn.
      send_request(0, ONE, 2*ONE, 3*ONE, 4*ONE, ONE/2);
      send_request(0, ONE, 2*ONE, 3*ONE, 4*ONE, ONE + ONE/3);
      send_request(0, ONE, 2*ONE, 3*ONE, 4*ONE, 2*ONE + 7);
      send_request(0, ONE, 2*ONE, 3*ONE, 4*ONE, 4*ONE - 2);
      // Double knots force a coefficient to one.
      send_request(0, ONE, 2*ONE, 2*ONE, 4*ONE, ONE + 5);
      send_request(0, ONE, ONE, 3*ONE, 4*ONE, 2*ONE + 5);
      // The widest support the format holds.
      send_request(KMIN, -ONE, 0, ONE, KMAX, 12345);
      send_request(KMIN, KMIN + 4, KMIN + 8, KMAX - 8, KMAX, KMIN + 2);
      send_request(KMIN, KMIN + 4, KMIN + 8, KMAX - 8, KMAX, KMAX - 2);
      // Out of bounds: on or next to the end knots, and beyond them.
      send_request(0, ONE, 2*ONE, 3*ONE, 4*ONE, 0);
      send_request(0, ONE, 2*ONE, 3*ONE, 4*ONE, 1);
      send_request(0, ONE, 2*ONE, 3*ONE, 4*ONE, 4*ONE - 1);
      send_request(0, ONE, 2*ONE, 3*ONE, 4*ONE, KMAX);
      send_request(0, ONE, 2*ONE, 3*ONE, 4*ONE, KMIN);
      send_request(KMAX, KMAX, KMAX, KMAX, KMAX, KMAX);
      // On an inner knot, exactly and within the tolerance, and just beyond it.
      send_request(0, ONE, 2*ONE, 3*ONE, 4*ONE, ONE);
      send_request(0, ONE, 2*ONE, 3*ONE, 4*ONE, 2*ONE + 1);
      send_request(0, ONE, 2*ONE, 3*ONE, 4*ONE, 3*ONE - 1);
      send_request(0, ONE, 2*ONE, 3*ONE, 4*ONE, 3*ONE - 2);
      // Unsorted inner knots with the new knot clear of all of them.
      send_request(0, 3*ONE, 2*ONE, ONE, 4*ONE, ONE/2);
      send_request(0, ONE, 2*ONE, 5*ONE, 4*ONE, ONE/2);
      send_request(0, -ONE, 2*ONE, 3*ONE, 4*ONE, ONE/2);

      // Random phases, each under its own tolerance.
      tol_plan[0] = ckb_pkg::TOL_RESET;
      tol_plan[1] = '0;
      tol_plan[2] = '1;
      tol_plan[3] = ckb_pkg::TOL_BITS'($urandom_range(2, 4000));
      tol_plan[4] = ckb_pkg::TOL_BITS'($urandom_range(0, 65535));
      foreach (tol_plan[p]) begin
         write_tolerance(tol_plan[p]);
         repeat (150) random_request();
      end
      req_chan.valid <= 1'b0;

      drain();
      if (board.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
